// ===== hdl/dssd_pkg.sv =====
// shared types, constants and glyph table for the seven-segment display driver
package dssd_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_WRITE_NUMBER = 2'd0,
        OP_WRITE_DIGIT  = 2'd1,
        OP_CLEAR_DIGIT  = 2'd2,
        OP_CLEAR_ALL    = 2'd3
    } op_t;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // field widths
    localparam int NUM_W  = 21;
    localparam int IDX_W  = 3;
    localparam int CODE_W = 5;
    localparam int SEG_W  = 7;

    // decimal conversion holds up to eight bcd digits
    localparam int BCD_DIGITS = 8;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 5;

    // positions packed into the two output words
    localparam int MAX_POS = 8;
    localparam int OUT_POS = 6;

    localparam logic [SEG_W-1:0]  SEG_MINUS  = 7'h40;
    localparam logic [CODE_W-1:0] CODE_MINUS = 5'd16;

    // hex glyph, segment a in bit 0
    function automatic logic [SEG_W-1:0] glyph7(input logic [3:0] v);
        logic [SEG_W-1:0] g;
        case (v)
            4'h0: g = 7'h3F;
            4'h1: g = 7'h06;
            4'h2: g = 7'h5B;
            4'h3: g = 7'h4F;
            4'h4: g = 7'h66;
            4'h5: g = 7'h6D;
            4'h6: g = 7'h7D;
            4'h7: g = 7'h07;
            4'h8: g = 7'h7F;
            4'h9: g = 7'h6F;
            4'hA: g = 7'h77;
            4'hB: g = 7'h7C;
            4'hC: g = 7'h39;
            4'hD: g = 7'h5E;
            4'hE: g = 7'h79;
            4'hF: g = 7'h71;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/decimal_seven_segment_display_top.sv =====
// seven-segment display driver top level with bit-serial binary to decimal conversion
//
//  channel  | direction | tdata                                   | tuser
//  ---------+-----------+-----------------------------------------+----------------
//  s_       | in        | number_value, digit_index, digit_code   | operation
//  m_       | out       | low_segments, high_segments             | range_error
//
// write number passes from its transfer through the double-dabble shift register, which
// takes one magnitude bit per cycle, and then a finish step that loads the output
// register. the other operations go from their transfer straight to the finish step.
// the next transfer is taken once the block is back in idle after the finish step.
// a new item is taken while a result waits in the output register; the finish step
// stalls until that register is free.
// aresetn is synchronous, active low, and blanks every position.
module decimal_seven_segment_display_top #(
    parameter int NUM_DIGITS = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [20:0] number_value, [23:21] digit_index, [28:24] digit_code, [31:29] zero
    input  logic [dssd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [dssd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] low_segments, [47:32] high_segments
    output logic [dssd_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] range_error
    output logic [dssd_pkg::M_TUSER_W-1:0] m_tuser
);
    import dssd_pkg::*;

    localparam logic [3:0] NUM_DIGITS_W = 4'(NUM_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                neg_reg, neg_next;
    logic [NUM_W-1:0]    mag_reg, mag_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SEG_W-1:0]    seg_reg [NUM_DIGITS];
    logic [SEG_W-1:0]    seg_next [NUM_DIGITS];
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                out_err_reg, out_err_next;

    logic                s_fire;
    logic                fin_fire;
    logic [NUM_W-1:0]    in_bits;
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          num_len;
    logic [3:0]          num_limit;
    logic                num_err;
    logic                idx_err;
    logic                fin_err;
    logic [MAX_POS-1:0][SEG_W-1:0] pos_seg;

    assign s_tready = state_reg == ST_IDLE;
    assign s_fire   = s_tvalid && s_tready;
    assign fin_fire = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign in_bits  = s_tdata[NUM_W-1:0];

    // add three to every bcd digit of five or more
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // significant decimal digits, at least one
    always_comb begin
        num_len = 4'd1;
        for (int d = 1; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                num_len = 4'(d + 1);
            end
        end
    end

    // range checks
    assign num_limit = neg_reg ? (NUM_DIGITS_W - 4'd1) : NUM_DIGITS_W;
    assign num_err   = num_len > num_limit;
    assign idx_err   = {1'b0, idx_reg} >= NUM_DIGITS_W;

    always_comb begin
        case (op_reg)
            OP_WRITE_NUMBER: fin_err = num_err;
            OP_WRITE_DIGIT:  fin_err = idx_err;
            OP_CLEAR_DIGIT:  fin_err = idx_err;
            default:         fin_err = 1'b0;
        endcase
    end

    // updated segment patterns for the finish step
    always_comb begin
        for (int p = 0; p < NUM_DIGITS; p++) begin
            seg_next[p] = seg_reg[p];
            if (fin_fire) begin
                case (op_reg)
                    OP_WRITE_NUMBER: begin
                        if (!num_err) begin
                            if (4'(p) < num_len) begin
                                seg_next[p] = glyph7(bcd_reg[4*p +: 4]);
                            end else if (neg_reg && (4'(p) == num_len)) begin
                                seg_next[p] = SEG_MINUS;
                            end
                        end
                    end
                    OP_WRITE_DIGIT: begin
                        if (idx_reg == IDX_W'(p)) begin
                            if (!code_reg[CODE_W-1]) begin
                                seg_next[p] = glyph7(code_reg[3:0]);
                            end else if (code_reg == CODE_MINUS) begin
                                seg_next[p] = SEG_MINUS;
                            end
                        end
                    end
                    OP_CLEAR_DIGIT: begin
                        if (idx_reg == IDX_W'(p)) begin
                            seg_next[p] = '0;
                        end
                    end
                    default: begin
                        seg_next[p] = '0;
                    end
                endcase
            end
        end
    end

    // positions beyond the display read as blank
    for (genvar gp = 0; gp < MAX_POS; gp++) begin : g_pos
        if (gp < NUM_DIGITS) begin : g_on
            assign pos_seg[gp] = seg_next[gp];
        end else begin : g_off
            assign pos_seg[gp] = '0;
        end
    end

    // pack both display words
    always_comb begin
        out_data_next = out_data_reg;
        out_err_next  = out_err_reg;
        if (fin_fire) begin
            out_data_next = '0;
            for (int p = 0; p < OUT_POS; p++) begin
                out_data_next[8*p +: SEG_W] = pos_seg[p];
            end
            out_err_next = fin_err;
        end
    end

    // control and shift register
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        idx_next      = idx_reg;
        code_next     = code_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next   = op_t'(s_tuser);
                    neg_next  = in_bits[NUM_W-1];
                    mag_next  = in_bits[NUM_W-1] ? (~in_bits + NUM_W'(1)) : in_bits;
                    idx_next  = s_tdata[NUM_W +: IDX_W];
                    code_next = s_tdata[NUM_W+IDX_W +: CODE_W];
                    bcd_next  = '0;
                    cnt_next  = '0;
                    if (op_t'(s_tuser) == OP_WRITE_NUMBER) begin
                        state_next = ST_CONV;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[NUM_W-1]};
                mag_next = {mag_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_fire) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int p = 0; p < NUM_DIGITS; p++) begin
                seg_reg[p] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int p = 0; p < NUM_DIGITS; p++) begin
                seg_reg[p] <= seg_next[p];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        idx_reg      <= idx_next;
        code_reg     <= code_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

// ===== hdl/dssd_checker.sv =====
// port-level checker for the seven-segment display driver, bound to the top level
module dssd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dssd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dssd_pkg::M_TUSER_W-1:0] m_tuser
);
    import dssd_pkg::*;

    logic                 s_xfer;
    logic                 m_xfer;
    logic [1:0]           pending_reg;
    logic [M_TDATA_W-1:0] last_data_reg;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // items taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_xfer) - 2'(m_xfer);
        end
    end

    // display words of the last delivered transfer, blank after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_data_reg <= '0;
        end else if (m_xfer) begin
            last_data_reg <= m_tdata;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result without an item behind it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without a pending item");

    // a range error leaves the display unchanged
    a_err_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && m_tuser[0] |-> m_tdata == last_data_reg)
        else $error("display changed on range error");

    // bit 7 of every position stays dark
    a_dp_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7] && !m_tdata[15] && !m_tdata[23] && !m_tdata[31]
                     && !m_tdata[39] && !m_tdata[47])
        else $error("unused segment bit set");

endmodule

bind decimal_seven_segment_display_top dssd_checker u_dssd_checker (.*);

// ===== bench/tb_decimal_seven_segment_display_top.sv =====
// self-checking testbench for the six-digit seven-segment display driver
module tb_decimal_seven_segment_display_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dssd_pkg::*;

    localparam int NUM_DIGITS = 6;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    // segment a in bit 0, hex glyphs 0 to F
    localparam logic [SEG_W-1:0] HEX_SEGMENTS [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

    typedef struct packed {
        logic [31:0] low;
        logic [15:0] high;
        logic        err;
    } display_words_t;

    // tracks the display contents and the words the block should report
    class display_scoreboard;
        logic [SEG_W-1:0] position_segs [NUM_DIGITS];
        display_words_t   expected_words [$];
        int               mismatches;

        function new();
            foreach (position_segs[p]) position_segs[p] = '0;
            mismatches = 0;
        endfunction

        // decimal conversion onto positions 0 upward, returns the range error
        function bit show_number(logic [NUM_W-1:0] raw);
            bit neg;
            int mag;
            int rest;
            int len;
            int limit;
            neg = raw[NUM_W-1];
            mag = int'({11'b0, raw});
            if (neg) mag = (1 << NUM_W) - mag;
            len = 0;
            rest = mag;
            do begin
                len++;
                rest = rest / 10;
            end while (rest != 0);
            // the minus sign takes one position of its own
            limit = neg ? NUM_DIGITS - 1 : NUM_DIGITS;
            if (len > limit) return 1'b1;
            for (int i = 0; i < len; i++) begin
                position_segs[i] = HEX_SEGMENTS[mag % 10];
                mag = mag / 10;
            end
            if (neg) position_segs[len] = SEG_MINUS;
            return 1'b0;
        endfunction

        // apply one accepted command and queue the words it should produce
        function void note_transfer(op_t op, logic [NUM_W-1:0] num,
                                    logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code);
            bit             err;
            display_words_t words;
            err = 1'b0;
            case (op)
                OP_WRITE_NUMBER: begin
                    err = show_number(num);
                end
                OP_WRITE_DIGIT: begin
                    if (int'(idx) >= NUM_DIGITS) err = 1'b1;
                    else if (code < CODE_MINUS) position_segs[idx] = HEX_SEGMENTS[code[3:0]];
                    else if (code == CODE_MINUS) position_segs[idx] = SEG_MINUS;
                    // undefined glyphs leave the position as it is
                end
                OP_CLEAR_DIGIT: begin
                    if (int'(idx) >= NUM_DIGITS) err = 1'b1;
                    else position_segs[idx] = '0;
                end
                default: begin
                    foreach (position_segs[p]) position_segs[p] = '0;
                end
            endcase
            words = '0;
            for (int p = 0; p < 4 && p < NUM_DIGITS; p++)
                words.low[8*p +: SEG_W] = position_segs[p];
            for (int p = 4; p < 6 && p < NUM_DIGITS; p++)
                words.high[8*(p-4) +: SEG_W] = position_segs[p];
            words.err = err;
            expected_words.push_back(words);
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            display_words_t want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result, actual %h / %b", $time, tdata, tuser);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (tdata[31:0] !== want.low) begin
                $display("%0t: low_segments expected %h actual %h",
                         $time, want.low, tdata[31:0]);
                mismatches++;
            end
            if (tdata[47:32] !== want.high) begin
                $display("%0t: high_segments expected %h actual %h",
                         $time, want.high, tdata[47:32]);
                mismatches++;
            end
            if (tuser !== want.err) begin
                $display("%0t: range_error expected %b actual %b", $time, want.err, tuser);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    display_scoreboard board;
    bit                burst;

    decimal_seven_segment_display_top #(
        .NUM_DIGITS(NUM_DIGITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2.0) aclk = ~aclk;
    end

    // gap or stall length: mostly short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // number with a chosen digit count, sometimes fully random bits
    function automatic logic [NUM_W-1:0] rand_number();
        int n;
        int mag;
        bit neg;
        if ($urandom_range(0, 4) == 0) return NUM_W'($urandom);
        n = $urandom_range(1, 7);
        neg = ($urandom_range(0, 1) == 1);
        if (n == 1) mag = $urandom_range(0, 9);
        else if (n == 7) mag = $urandom_range(1000000, 1048575);
        else mag = $urandom_range(10 ** (n - 1), 10 ** n - 1);
        return NUM_W'(neg ? -mag : mag);
    endfunction

    // one input transfer, then an optional idle gap; returns at a falling edge
    task automatic send_command(op_t op, logic [NUM_W-1:0] num,
                                logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code);
        int gap;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, code, idx, num};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        gap = 0;
        if (!burst && $urandom_range(0, 99) >= 45) gap = pick_pause();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // result side back-pressure, with stretches of steady acceptance
    initial begin
        int  stall_left;
        int  span_left;
        bit  steady;
        m_tready   = 1'b0;
        stall_left = 0;
        span_left  = 0;
        steady     = 1'b0;
        forever begin
            @(negedge aclk);
            if (span_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                span_left = $urandom_range(100, 600);
            end
            span_left--;
            if (steady) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 25) begin
                m_tready   = 1'b0;
                stall_left = pick_pause() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // monitor both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                board.note_transfer(op_t'(s_tuser), s_tdata[20:0], s_tdata[23:21],
                                    s_tdata[28:24]);
        end
    end

    // watchdog
    initial begin
        #(CLK_PERIOD * 1000000);
        $display("FAILURE");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int                r;
        int                wait_cycles;
        op_t               op;
        logic [NUM_W-1:0]  num;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;

        board    = new();
        burst    = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, every operation, the corner cases
        send_command(OP_CLEAR_ALL,    '0, '0, '0);
        send_command(OP_WRITE_NUMBER, '0, '0, '0);                  // zero shows "0"
        send_command(OP_WRITE_NUMBER, NUM_W'(999999), '0, '0);      // widest positive
        send_command(OP_WRITE_NUMBER, NUM_W'(1000000), '0, '0);     // one digit too many
        send_command(OP_WRITE_NUMBER, NUM_W'(1048575), 3'd7, 5'd31);
        send_command(OP_WRITE_NUMBER, NUM_W'(-99999), '0, '0);      // widest negative
        send_command(OP_WRITE_NUMBER, NUM_W'(-100000), '0, '0);     // no room for the sign
        send_command(OP_WRITE_NUMBER, NUM_W'(-1048576), '0, '0);    // most negative
        send_command(OP_WRITE_NUMBER, NUM_W'(-1), '0, '0);          // upper positions kept
        send_command(OP_WRITE_NUMBER, NUM_W'(7), '0, '0);
        send_command(OP_WRITE_DIGIT,  '0, 3'd5, 5'd15);
        send_command(OP_WRITE_DIGIT,  '0, 3'd0, CODE_MINUS);
        send_command(OP_WRITE_DIGIT,  '0, 3'd1, 5'd0);
        send_command(OP_WRITE_DIGIT,  '0, 3'd6, 5'd3);              // index out of range
        send_command(OP_WRITE_DIGIT,  '0, 3'd7, 5'd31);
        send_command(OP_WRITE_DIGIT,  '0, 3'd2, 5'd17);             // undefined glyph
        send_command(OP_WRITE_DIGIT,  '0, 3'd3, 5'd31);
        send_command(OP_CLEAR_DIGIT,  '0, 3'd0, '0);
        send_command(OP_CLEAR_DIGIT,  '0, 3'd5, '0);
        send_command(OP_CLEAR_DIGIT,  '0, 3'd6, '0);
        send_command(OP_CLEAR_DIGIT,  '1, 3'd7, '1);
        send_command(OP_CLEAR_ALL,    '1, '1, '1);
        send_command(OP_WRITE_NUMBER, NUM_W'(-5), '0, '0);

        // random commands with all fields randomized
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
            // hold off until the block has drained
            if (i == RANDOM_ITEMS / 2) begin
                s_tvalid = 1'b0;
                while (board.pending() > 0) @(negedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 40) op = OP_WRITE_NUMBER;
            else if (r < 70) op = OP_WRITE_DIGIT;
            else if (r < 93) op = OP_CLEAR_DIGIT;
            else op = OP_CLEAR_ALL;
            num  = rand_number();
            idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(6, 7))
                                               : IDX_W'($urandom_range(0, 5));
            code = ($urandom_range(0, 7) == 0) ? CODE_W'($urandom_range(17, 31))
                                               : CODE_W'($urandom_range(0, 16));
            send_command(op, num, idx, code);
        end
        s_tvalid = 1'b0;

        // drain the remaining results
        wait_cycles = 0;
        while (board.pending() > 0 && wait_cycles < DRAIN_LIMIT) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (board.pending() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dssd_pkg.sv
hdl/decimal_seven_segment_display_top.sv
hdl/dssd_checker.sv
bench/tb_decimal_seven_segment_display_top.sv
